// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/tpc_pkg.sv =====
package tpc_pkg;

	localparam int NATTR    = 6;
	localparam int ATTR_W   = 32;
	localparam int NORM_W   = 16;
	localparam int DIFF_W   = 33;
	localparam int MUL_A_W  = 34;
	localparam int MUL_B_W  = 17;
	localparam int PROD_W   = 51;
	localparam int DIST_W   = 51;
	localparam int REM_W    = 52;
	localparam int T_W      = 31;
	localparam int LACC_W   = 64;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PZ = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NZ = 3'd5;

	localparam logic signed [NORM_W-1:0] NORM_Y_RESET = 16'sd16384;

	typedef logic signed [ATTR_W-1:0] attr_t;

	typedef struct packed {
		attr_t in_x;
		attr_t in_y;
		attr_t in_z;
		attr_t in_u;
		attr_t in_v;
		attr_t in_light;
	} in_vtx_t;

	typedef struct packed {
		attr_t out_x;
		attr_t out_y;
		attr_t out_z;
		attr_t out_u;
		attr_t out_v;
		attr_t out_light;
		logic  last_vertex;
	} out_vtx_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_VIN,
		OP_DSUB,
		OP_DMUL,
		OP_DACC,
		OP_DIVINIT,
		OP_DIVSTEP,
		OP_LSUB,
		OP_LMULLO,
		OP_LACCLO,
		OP_LACCHI,
		OP_LWRITE,
		OP_OUTV,
		OP_OUTX
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] vtx;
		logic [2:0] attr;
		logic [1:0] vin;
		logic [1:0] vout;
		logic       last;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] ins;
		logic       out_free;
	} dp_sts_t;

endpackage

// ===== hdl/tpc_stream_if.sv =====
interface tpc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/triangle_plane_clipper.sv =====
// Channel   Dir  Payload                                   Handshake
// in_ch     in   in_x, in_y, in_z, in_u, in_v, in_light    valid/ready
// out_ch    out  out_x .. out_light, last_vertex           valid/ready
// cfg       in   cfg_index (3b), cfg_data (32b)            cfg_we, no stall
//
// Vertices one and two are only stored; the third also starts the plane
// distances (3 vertices x 3 axes x 3 phases through one multiplier). A kept
// vertex is then planned and emitted; an edge crossing takes setup, a 31-step
// restoring divide, interpolation per attribute, emit; no vertex inside: no output.
// Reset clears the slot, controller and output valid and reloads the plane.
// Input waits while busy; a held output transaction stalls the next emit.
module triangle_plane_clipper (
	input  logic                          clk,
	input  logic                          arst_n,
	tpc_stream_if.sink                    in_ch,
	tpc_stream_if.source                  out_ch,
	input  logic                          cfg_we,
	input  logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tpc_pkg::ATTR_W-1:0]    cfg_data
);

	tpc_pkg::dp_cmd_t cmd;
	tpc_pkg::dp_sts_t sts;

	// sequence each triangle: store, measure, then emit kept vertices and crossings
	tpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// vertex store, distance MAC, divider, interpolator and output register
	tpc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_ch.data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_data  (out_ch.data)
	);

endmodule

// ===== hdl/tpc_ctrl.sv =====
`include "assert_macros.svh"

module tpc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tpc_pkg::dp_sts_t  sts,
	output tpc_pkg::dp_cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIST = 6'b000010,
		ST_PLAN = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_LERP = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		PK_NONE,
		PK_VERT,
		PK_CROSS
	} plan_kind_t;

	state_t     state_q, state_d;
	logic [1:0] slot_q, slot_d;
	logic [1:0] step_q, step_d;
	logic [1:0] cnt_a_q, cnt_a_d;
	logic [2:0] cnt_b_q, cnt_b_d;
	logic [2:0] ph_q, ph_d;
	logic [4:0] it_q, it_d;

	plan_kind_t kind;
	logic [1:0] p_vin, p_vout;
	logic       p_last;
	logic [1:0] n_in;
	logic [1:0] o2i, a2i, b2i, a1i, o11, o12;
	logic       emit_go;

	// emission plan for the current step of the triangle
	always_comb begin
		n_in = 2'(sts.ins[0]) + 2'(sts.ins[1]) + 2'(sts.ins[2]);
		o2i = !sts.ins[0] ? 2'd0 : (!sts.ins[1] ? 2'd1 : 2'd2);
		a2i = (o2i == 2'd0) ? 2'd1 : 2'd0;
		b2i = (o2i == 2'd2) ? 2'd1 : 2'd2;
		a1i = sts.ins[0] ? 2'd0 : (sts.ins[1] ? 2'd1 : 2'd2);
		o11 = (a1i == 2'd0) ? 2'd1 : 2'd0;
		o12 = (a1i == 2'd2) ? 2'd1 : 2'd2;
		kind = PK_NONE;
		p_vin = 2'd0;
		p_vout = 2'd0;
		p_last = 1'b0;
		case (n_in)
			2'd3: begin
				kind = (step_q == 2'd3) ? PK_NONE : PK_VERT;
				p_vin = step_q;
				p_last = (step_q == 2'd2);
			end
			2'd2: begin
				case (step_q)
					2'd0: begin kind = PK_VERT; p_vin = a2i; end
					2'd1: begin kind = PK_VERT; p_vin = b2i; end
					2'd2: begin kind = PK_CROSS; p_vin = a2i; p_vout = o2i; end
					default: begin
						kind = PK_CROSS; p_vin = b2i; p_vout = o2i; p_last = 1'b1;
					end
				endcase
			end
			2'd1: begin
				case (step_q)
					2'd0: begin kind = PK_VERT; p_vin = a1i; end
					2'd1: begin kind = PK_CROSS; p_vin = a1i; p_vout = o11; end
					2'd2: begin
						kind = PK_CROSS; p_vin = a1i; p_vout = o12; p_last = 1'b1;
					end
					default: kind = PK_NONE;
				endcase
			end
			default: kind = PK_NONE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign emit_go = (state_q == ST_EMIT) && sts.out_free;

	always_comb begin
		cmd.op = tpc_pkg::OP_NONE;
		cmd.vtx = p_vin;
		cmd.attr = cnt_b_q;
		cmd.vin = p_vin;
		cmd.vout = p_vout;
		cmd.last = p_last;
		state_d = state_q;
		slot_d = slot_q;
		step_d = step_q;
		cnt_a_d = cnt_a_q;
		cnt_b_d = cnt_b_q;
		ph_d = ph_q;
		it_d = it_q;
		case (state_q)
			ST_IDLE: begin
				cmd.vtx = slot_q;
				if (in_valid) begin
					cmd.op = tpc_pkg::OP_VIN;
					if (slot_q == 2'd2) begin
						slot_d = 2'd0;
						cnt_a_d = 2'd0;
						cnt_b_d = 3'd0;
						ph_d = 3'd0;
						state_d = ST_DIST;
					end else begin
						slot_d = slot_q + 2'd1;
					end
				end
			end
			ST_DIST: begin
				cmd.vtx = cnt_a_q;
				case (ph_q)
					3'd0: cmd.op = tpc_pkg::OP_DSUB;
					3'd1: cmd.op = tpc_pkg::OP_DMUL;
					default: cmd.op = tpc_pkg::OP_DACC;
				endcase
				if (ph_q == 3'd2) begin
					ph_d = 3'd0;
					if (cnt_b_q == 3'd2) begin
						cnt_b_d = 3'd0;
						if (cnt_a_q == 2'd2) begin
							step_d = 2'd0;
							state_d = ST_PLAN;
						end else begin
							cnt_a_d = cnt_a_q + 2'd1;
						end
					end else begin
						cnt_b_d = cnt_b_q + 3'd1;
					end
				end else begin
					ph_d = ph_q + 3'd1;
				end
			end
			ST_PLAN: begin
				case (kind)
					PK_VERT: state_d = ST_EMIT;
					PK_CROSS: begin
						cmd.op = tpc_pkg::OP_DIVINIT;
						it_d = 5'd0;
						state_d = ST_DIV;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_DIV: begin
				cmd.op = tpc_pkg::OP_DIVSTEP;
				if (it_q == 5'(tpc_pkg::T_W - 1)) begin
					cnt_b_d = 3'd0;
					ph_d = 3'd0;
					state_d = ST_LERP;
				end else begin
					it_d = it_q + 5'd1;
				end
			end
			ST_LERP: begin
				case (ph_q)
					3'd0: cmd.op = tpc_pkg::OP_LSUB;
					3'd1: cmd.op = tpc_pkg::OP_LMULLO;
					3'd2: cmd.op = tpc_pkg::OP_LACCLO;
					3'd3: cmd.op = tpc_pkg::OP_LACCHI;
					default: cmd.op = tpc_pkg::OP_LWRITE;
				endcase
				if (ph_q == 3'd4) begin
					ph_d = 3'd0;
					if (cnt_b_q == 3'(tpc_pkg::NATTR - 1)) begin
						state_d = ST_EMIT;
					end else begin
						cnt_b_d = cnt_b_q + 3'd1;
					end
				end else begin
					ph_d = ph_q + 3'd1;
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					cmd.op = (kind == PK_VERT) ? tpc_pkg::OP_OUTV : tpc_pkg::OP_OUTX;
					if (p_last) begin
						state_d = ST_IDLE;
					end else begin
						step_d = step_q + 2'd1;
						state_d = ST_PLAN;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q <= 2'd0;
			step_q <= 2'd0;
			cnt_a_q <= 2'd0;
			cnt_b_q <= 3'd0;
			ph_q <= 3'd0;
			it_q <= 5'd0;
		end else begin
			state_q <= state_d;
			slot_q <= slot_d;
			step_q <= step_d;
			cnt_a_q <= cnt_a_d;
			cnt_b_q <= cnt_b_d;
			ph_q <= ph_d;
			it_q <= it_d;
		end
	end

	`ASSERT_SAME(a_emit_free, clk, arst_n, (cmd.op == tpc_pkg::OP_OUTV || cmd.op == tpc_pkg::OP_OUTX), sts.out_free)
	`ASSERT_SAME(a_slot_range, clk, arst_n, 1'b1, slot_q != 2'd3)
	`ASSERT_NEXT(a_last_idle, clk, arst_n, (emit_go && p_last), state_q == ST_IDLE)
	`ASSERT_SAME(a_cross_dir, clk, arst_n, (state_q == ST_DIV), (sts.ins[cmd.vin] && !sts.ins[cmd.vout]))

endmodule

// ===== hdl/tpc_datapath.sv =====
module tpc_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tpc_pkg::in_vtx_t                     in_data,
	input  logic                                 cfg_we,
	input  logic [tpc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tpc_pkg::ATTR_W-1:0]           cfg_data,
	input  tpc_pkg::dp_cmd_t                     cmd,
	output tpc_pkg::dp_sts_t                     sts,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output tpc_pkg::out_vtx_t                    out_data
);

	tpc_pkg::attr_t                   pp_q [3];
	logic signed [tpc_pkg::NORM_W-1:0] nrm_q [3];

	tpc_pkg::attr_t                   vtx_q [3][tpc_pkg::NATTR];
	tpc_pkg::attr_t                   cross_q [tpc_pkg::NATTR];
	logic signed [tpc_pkg::DIST_W-1:0] dist_q [3];
	logic signed [tpc_pkg::DIST_W-1:0] acc_q;
	logic signed [tpc_pkg::DIFF_W-1:0] diff_q;
	logic signed [tpc_pkg::PROD_W-1:0] prod_q;
	logic [tpc_pkg::REM_W-1:0]         rem_q;
	logic [tpc_pkg::DIST_W-1:0]        den_q;
	logic [tpc_pkg::T_W-1:0]           t_q;
	logic [tpc_pkg::DIFF_W-1:0]        mag_q;
	logic                              neg_q;
	logic [tpc_pkg::LACC_W-1:0]        lacc_q;
	tpc_pkg::out_vtx_t                 out_q;
	logic                              out_valid_q;

	tpc_pkg::attr_t                    in_arr [tpc_pkg::NATTR];
	tpc_pkg::attr_t                    la, lb;
	logic signed [tpc_pkg::MUL_A_W-1:0] ma;
	logic signed [tpc_pkg::MUL_B_W-1:0] mb;
	logic signed [tpc_pkg::PROD_W-1:0]  prod_d;
	logic signed [tpc_pkg::DIST_W-1:0]  acc_d;
	logic signed [tpc_pkg::DIFF_W-1:0]  delta;
	logic [tpc_pkg::REM_W-1:0]          rem_sh;
	logic [tpc_pkg::DIFF_W-1:0]         q_l;
	logic signed [34:0]                 r_l;
	tpc_pkg::attr_t                     r_sat;
	logic [1:0]                         ax;

	assign in_arr[0] = in_data.in_x;
	assign in_arr[1] = in_data.in_y;
	assign in_arr[2] = in_data.in_z;
	assign in_arr[3] = in_data.in_u;
	assign in_arr[4] = in_data.in_v;
	assign in_arr[5] = in_data.in_light;

	assign ax = cmd.attr[1:0];
	assign la = vtx_q[cmd.vin][cmd.attr];
	assign lb = vtx_q[cmd.vout][cmd.attr];

	// shared multiplier: plane distance terms and interpolation partial products
	always_comb begin
		ma = {diff_q[tpc_pkg::DIFF_W-1], diff_q};
		mb = {nrm_q[ax][tpc_pkg::NORM_W-1], nrm_q[ax]};
		case (cmd.op)
			tpc_pkg::OP_LMULLO: begin
				ma = {1'b0, mag_q};
				mb = {1'b0, t_q[15:0]};
			end
			tpc_pkg::OP_LACCLO: begin
				ma = {1'b0, mag_q};
				mb = {2'b00, t_q[tpc_pkg::T_W-1:16]};
			end
			default: ;
		endcase
		prod_d = ma * mb;
	end

	always_comb begin
		acc_d = ((ax == 2'd0) ? '0 : acc_q) + prod_q;
		delta = {lb[tpc_pkg::ATTR_W-1], lb} - {la[tpc_pkg::ATTR_W-1], la};
		rem_sh = {rem_q[tpc_pkg::REM_W-2:0], 1'b0};
		q_l = lacc_q[tpc_pkg::LACC_W-1:tpc_pkg::T_W];
		r_l = neg_q ? (35'(la) - 35'({1'b0, q_l})) : (35'(la) + 35'({1'b0, q_l}));
		if (r_l > 35'sd2147483647) begin
			r_sat = 32'sh7fffffff;
		end else if (r_l < -35'sd2147483648) begin
			r_sat = 32'sh80000000;
		end else begin
			r_sat = r_l[31:0];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			tpc_pkg::OP_VIN: begin
				for (int j = 0; j < tpc_pkg::NATTR; j++) begin
					vtx_q[cmd.vtx][j] <= in_arr[j];
				end
			end
			tpc_pkg::OP_DSUB: begin
				diff_q <= {vtx_q[cmd.vtx][ax][tpc_pkg::ATTR_W-1], vtx_q[cmd.vtx][ax]}
					- {pp_q[ax][tpc_pkg::ATTR_W-1], pp_q[ax]};
			end
			tpc_pkg::OP_DMUL: prod_q <= prod_d;
			tpc_pkg::OP_DACC: begin
				acc_q <= acc_d;
				if (ax == 2'd2) begin
					dist_q[cmd.vtx] <= acc_d;
				end
			end
			tpc_pkg::OP_DIVINIT: begin
				rem_q <= tpc_pkg::REM_W'(unsigned'(dist_q[cmd.vin]));
				den_q <= unsigned'(dist_q[cmd.vin] - dist_q[cmd.vout]);
				t_q <= '0;
			end
			tpc_pkg::OP_DIVSTEP: begin
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q <= rem_sh - {1'b0, den_q};
					t_q <= {t_q[tpc_pkg::T_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					t_q <= {t_q[tpc_pkg::T_W-2:0], 1'b0};
				end
			end
			tpc_pkg::OP_LSUB: begin
				neg_q <= delta[tpc_pkg::DIFF_W-1];
				mag_q <= delta[tpc_pkg::DIFF_W-1] ? unsigned'(-delta) : unsigned'(delta);
			end
			tpc_pkg::OP_LMULLO: prod_q <= prod_d;
			tpc_pkg::OP_LACCLO: begin
				lacc_q <= {16'b0, prod_q[47:0]};
				prod_q <= prod_d;
			end
			tpc_pkg::OP_LACCHI: lacc_q <= lacc_q + {prod_q[47:0], 16'b0};
			tpc_pkg::OP_LWRITE: cross_q[cmd.attr] <= r_sat;
			tpc_pkg::OP_OUTV: begin
				out_q <= {vtx_q[cmd.vtx][0], vtx_q[cmd.vtx][1], vtx_q[cmd.vtx][2],
					vtx_q[cmd.vtx][3], vtx_q[cmd.vtx][4], vtx_q[cmd.vtx][5], cmd.last};
			end
			tpc_pkg::OP_OUTX: begin
				out_q <= {cross_q[0], cross_q[1], cross_q[2], cross_q[3], cross_q[4],
					cross_q[5], cmd.last};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pp_q[0] <= '0;
			pp_q[1] <= '0;
			pp_q[2] <= '0;
			nrm_q[0] <= '0;
			nrm_q[1] <= tpc_pkg::NORM_Y_RESET;
			nrm_q[2] <= '0;
		end else begin
			if (cmd.op == tpc_pkg::OP_OUTV || cmd.op == tpc_pkg::OP_OUTX) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					tpc_pkg::CFG_PX: pp_q[0] <= cfg_data;
					tpc_pkg::CFG_PY: pp_q[1] <= cfg_data;
					tpc_pkg::CFG_PZ: pp_q[2] <= cfg_data;
					tpc_pkg::CFG_NX: nrm_q[0] <= cfg_data[tpc_pkg::NORM_W-1:0];
					tpc_pkg::CFG_NY: nrm_q[1] <= cfg_data[tpc_pkg::NORM_W-1:0];
					tpc_pkg::CFG_NZ: nrm_q[2] <= cfg_data[tpc_pkg::NORM_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign sts.ins[0] = !dist_q[0][tpc_pkg::DIST_W-1];
	assign sts.ins[1] = !dist_q[1][tpc_pkg::DIST_W-1];
	assign sts.ins[2] = !dist_q[2][tpc_pkg::DIST_W-1];
	assign sts.out_free = !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
